@@ rtl/gdo_pkg.sv @@
// Shared types, constants and helper functions for the Gregorian date offset unit.
// Holds the microcode word format, step addresses and the calendar arithmetic.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package gdo_pkg;

    // Largest year the block accepts, clamped to what the 14-bit year field holds.
    localparam int MAX_YEAR       = 9999;
    localparam int YEAR_FIELD_MAX = 16383;
    localparam int YEAR_LIM       = (MAX_YEAR > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX : MAX_YEAR;

    // Field widths of the transactions.
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 17;

    // Working widths: the year carries one extra bit so an increment past the
    // largest 14-bit year does not wrap; the day count holds day of year plus offset.
    localparam int WYEAR_W = YEAR_W + 1;
    localparam int DAYS_W  = OFFSET_W + 1;

    localparam int MONTHS         = 12;
    localparam int DAYS_LEAP_YEAR = 366;
    localparam int DAYS_YEAR      = 365;
    localparam int DAYS_LEAP_FEB  = 29;
    localparam int FEBRUARY       = 2;

    // Month lengths of a common year, indexed by month number.
    localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS+1] =
        '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    // Reciprocal of 100 scaled by 2^19; exact quotient for all 15-bit years.
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_100   = 5243;
    localparam int PROD_W      = 28;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // Microcode program counter.
    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    // Step addresses of the microprogram.
    localparam pc_t S_LOAD   = 5'd0;
    localparam pc_t S_SPLIT  = 5'd1;
    localparam pc_t S_SET    = 5'd2;
    localparam pc_t S_MSUM   = 5'd3;
    localparam pc_t S_MADD   = 5'd4;
    localparam pc_t S_OFF    = 5'd5;
    localparam pc_t S_BCHK   = 5'd6;
    localparam pc_t S_BDEC   = 5'd7;
    localparam pc_t S_BWAIT  = 5'd8;
    localparam pc_t S_BADD   = 5'd9;
    localparam pc_t S_FCHK   = 5'd10;
    localparam pc_t S_FSUB   = 5'd11;
    localparam pc_t S_FWAIT  = 5'd12;
    localparam pc_t S_MFIRST = 5'd13;
    localparam pc_t S_MCHK   = 5'd14;
    localparam pc_t S_MSUB   = 5'd15;
    localparam pc_t S_COMMIT = 5'd16;
    localparam pc_t S_FAIL   = 5'd17;
    localparam pc_t S_DONE   = 5'd18;

    // Datapath operations selected by one control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SET_CHK,
        OP_ADD_MON,
        OP_ADD_OFF,
        OP_DEC_YR,
        OP_ADD_YEAR,
        OP_SUB_YEAR,
        OP_MON_ONE,
        OP_SUB_MON,
        OP_COMMIT,
        OP_FAIL,
        OP_EMIT
    } op_t;

    // Branch conditions tested by one control word.
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_FUNC,
        C_MSUM_DONE,
        C_DAYS_POS,
        C_YR_ZERO,
        C_YR_OVER,
        C_DAYS_LE_DIY,
        C_DAYS_LE_DIM,
        C_OUT_FREE
    } cond_t;

    // One microcode word: operation, branch test, end flag, taken and fall targets.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  fin;
        pc_t   tgt_t;
        pc_t   tgt_f;
    } ucw_t;

    // Status flags that the datapath reports to the sequencer.
    typedef struct packed {
        logic func;
        logic msum_done;
        logic days_pos;
        logic yr_zero;
        logic yr_over;
        logic days_le_diy;
        logic days_le_dim;
        logic out_free;
    } flags_t;

    // Builds one control word.
    function automatic ucw_t uc(input op_t op, input cond_t c, input logic fin,
                                input pc_t tt, input pc_t tf);
        ucw_t w;
        w.op    = op;
        w.cond  = c;
        w.fin   = fin;
        w.tgt_t = tt;
        w.tgt_f = tf;
        return w;
    endfunction

    // Gregorian leap rule; the quotient by 100 comes from a reciprocal multiply.
    function automatic logic is_leap(input logic [WYEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] q;
        logic [WYEAR_W:0]  q100;
        logic              hund;
        prod = PROD_W'(y) * PROD_W'(RECIP_100);
        q    = prod[PROD_W-1:RECIP_SHIFT];
        q100 = (WYEAR_W+1)'(q) * (WYEAR_W+1)'(100);
        hund = ({1'b0, y} == q100);
        return (y[1:0] == 2'b00) && (!hund || (q[1:0] == 2'b00));
    endfunction

    // Length of a month; zero for a month number outside 1 to 12.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        if ((m == '0) || (m > MONTH_W'(MONTHS))) begin
            len = '0;
        end else if ((m == MONTH_W'(FEBRUARY)) && leap) begin
            len = DAY_W'(DAYS_LEAP_FEB);
        end else begin
            len = MONTH_LEN[m];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gregorian_date_offset_unit.sv @@
// Gregorian date offset unit, top level.
// One stream channel in (s_*) and one out (m_*). An input transaction either sets
// the stored date (s_tuser = 0) or advances it by a signed day offset (s_tuser = 1).
// Every input transaction gives exactly one output transaction with an ok flag and
// the stored date as it stands afterwards; a rejected item leaves the date as is.
// Items are worked one at a time by a microcoded sequencer driving one datapath.
// A set runs the load, split, set-check and result steps. An advance runs load
// and split, walks the months before the stored month, adds the offset, walks
// the years backward or forward, then walks the months before the target month;
// an offset near 65535 days walks about 180 years. The year walk takes most of an
// advance: the leap flag is registered after each year step, so each year costs one wait.
// The next item is accepted as soon as the previous result sits in the output
// register, even if the receiver has not taken it yet.
// When the receiver stalls, the result holds in that register and a following
// item waits at its last step.
// Reset (aresetn low, synchronous) clears the stored date to 0.0.0, empties the
// output register and returns the sequencer to idle.
// Depends on gdo_pkg, gdo_sequencer, gdo_ucode_rom and gdo_datapath.
`default_nettype none

module gregorian_date_offset_unit
    import gdo_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // year_in[13:0], month_in[17:14], day_in[22:18],
                                   // day_offset[39:23]
    input  wire         s_tuser,   // func: 0 set date, 1 advance
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata    // ok[0], year_out[14:1], month_out[18:15],
                                   // day_out[23:19]
);

    logic               accept;
    logic               busy;
    op_t                op;
    flags_t             flags;
    logic               ok_out;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;

    // A new transaction is taken whenever the sequencer is idle.
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    gdo_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .flags   (flags),
        .op      (op),
        .busy    (busy)
    );

    gdo_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .func_in    (s_tuser),
        .year_in    (s_tdata[13:0]),
        .month_in   (s_tdata[17:14]),
        .day_in     (s_tdata[22:18]),
        .day_offset ($signed(s_tdata[39:23])),
        .op         (op),
        .flags      (flags),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .ok_out     (ok_out),
        .year_out   (year_out),
        .month_out  (month_out),
        .day_out    (day_out)
    );

    // Pack the result fields, lowest first.
    assign m_tdata = {day_out, month_out, year_out, ok_out};

endmodule

`default_nettype wire

@@ rtl/gdo_ucode_rom.sv @@
// Microprogram of the date offset unit: one control word per step address.
// Depends on gdo_pkg for the word format, operations, conditions and addresses.
`default_nettype none

module gdo_ucode_rom
    import gdo_pkg::*;
(
    input  wire pc_t  addr,
    output ucw_t      word
);

    // Program table; unused addresses fall to the failure step.
    always_comb begin
        case (addr)
            S_LOAD:   word = uc(OP_LOAD,     C_ALWAYS,      1'b0, S_SPLIT,  S_SPLIT);
            S_SPLIT:  word = uc(OP_NOP,      C_FUNC,        1'b0, S_MSUM,   S_SET);
            S_SET:    word = uc(OP_SET_CHK,  C_ALWAYS,      1'b0, S_DONE,   S_DONE);
            S_MSUM:   word = uc(OP_NOP,      C_MSUM_DONE,   1'b0, S_OFF,    S_MADD);
            S_MADD:   word = uc(OP_ADD_MON,  C_ALWAYS,      1'b0, S_MSUM,   S_MSUM);
            S_OFF:    word = uc(OP_ADD_OFF,  C_ALWAYS,      1'b0, S_BCHK,   S_BCHK);
            S_BCHK:   word = uc(OP_NOP,      C_DAYS_POS,    1'b0, S_FCHK,   S_BDEC);
            S_BDEC:   word = uc(OP_DEC_YR,   C_YR_ZERO,     1'b0, S_FAIL,   S_BWAIT);
            S_BWAIT:  word = uc(OP_NOP,      C_ALWAYS,      1'b0, S_BADD,   S_BADD);
            S_BADD:   word = uc(OP_ADD_YEAR, C_ALWAYS,      1'b0, S_BCHK,   S_BCHK);
            S_FCHK:   word = uc(OP_NOP,      C_DAYS_LE_DIY, 1'b0, S_MFIRST, S_FSUB);
            S_FSUB:   word = uc(OP_SUB_YEAR, C_ALWAYS,      1'b0, S_FWAIT,  S_FWAIT);
            S_FWAIT:  word = uc(OP_NOP,      C_YR_OVER,     1'b0, S_FAIL,   S_FCHK);
            S_MFIRST: word = uc(OP_MON_ONE,  C_ALWAYS,      1'b0, S_MCHK,   S_MCHK);
            S_MCHK:   word = uc(OP_NOP,      C_DAYS_LE_DIM, 1'b0, S_COMMIT, S_MSUB);
            S_MSUB:   word = uc(OP_SUB_MON,  C_ALWAYS,      1'b0, S_MCHK,   S_MCHK);
            S_COMMIT: word = uc(OP_COMMIT,   C_ALWAYS,      1'b0, S_DONE,   S_DONE);
            S_FAIL:   word = uc(OP_FAIL,     C_ALWAYS,      1'b0, S_DONE,   S_DONE);
            S_DONE:   word = uc(OP_EMIT,     C_OUT_FREE,    1'b1, S_LOAD,   S_DONE);
            default:  word = uc(OP_NOP,      C_ALWAYS,      1'b0, S_FAIL,   S_FAIL);
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/gdo_sequencer.sv @@
// Microcode sequencer: step counter, branch test and busy flag.
// Depends on gdo_pkg and instantiates gdo_ucode_rom.
`default_nettype none

module gdo_sequencer
    import gdo_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire flags_t flags,
    output op_t         op,
    output logic        busy
);

    pc_t  pc_reg, pc_next;
    logic busy_reg, busy_next;
    ucw_t word;
    logic hit;

    gdo_ucode_rom u_rom (
        .addr (pc_reg),
        .word (word)
    );

    // Select the branch condition named by the current word.
    always_comb begin
        case (word.cond)
            C_ALWAYS:      hit = 1'b1;
            C_FUNC:        hit = flags.func;
            C_MSUM_DONE:   hit = flags.msum_done;
            C_DAYS_POS:    hit = flags.days_pos;
            C_YR_ZERO:     hit = flags.yr_zero;
            C_YR_OVER:     hit = flags.yr_over;
            C_DAYS_LE_DIY: hit = flags.days_le_diy;
            C_DAYS_LE_DIM: hit = flags.days_le_dim;
            C_OUT_FREE:    hit = flags.out_free;
            default:       hit = 1'b1;
        endcase
    end

    // Next step: start the program on a new transaction, otherwise branch.
    always_comb begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                pc_next   = S_LOAD;
            end
        end else begin
            pc_next = hit ? word.tgt_t : word.tgt_f;
            if (word.fin && hit) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= S_LOAD;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign op   = busy_reg ? word.op : OP_NOP;
    assign busy = busy_reg;

    // The program ends only through the result step, once the output is free.
    a_end_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (word.op == OP_EMIT) && flags.out_free) |=> !busy_reg)
        else $error("sequencer did not finish after emitting a result");

    // The step counter stays inside the program while busy.
    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg <= S_DONE))
        else $error("step counter left the program");

endmodule

`default_nettype wire

@@ rtl/gdo_datapath.sv @@
// Datapath of the date offset unit: input latch, working year, day count,
// month counter, leap flag, stored date and the output register.
// Depends on gdo_pkg; driven by the operation code from gdo_sequencer.
`default_nettype none

module gdo_datapath
    import gdo_pkg::*;
(
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        accept,
    input  wire                        func_in,
    input  wire  [YEAR_W-1:0]          year_in,
    input  wire  [MONTH_W-1:0]         month_in,
    input  wire  [DAY_W-1:0]           day_in,
    input  wire  signed [OFFSET_W-1:0] day_offset,
    input  wire  op_t                  op,
    output flags_t                     flags,
    input  wire                        out_ready,
    output logic                       out_valid,
    output logic                       ok_out,
    output logic [YEAR_W-1:0]          year_out,
    output logic [MONTH_W-1:0]         month_out,
    output logic [DAY_W-1:0]           day_out
);

    // Latched input transaction.
    logic                       func_reg;
    logic [YEAR_W-1:0]          yin_reg;
    logic [MONTH_W-1:0]         min_reg;
    logic [DAY_W-1:0]           din_reg;
    logic signed [OFFSET_W-1:0] off_reg;

    // Working registers.
    logic [WYEAR_W-1:0]       yr_reg, yr_next;
    logic [MONTH_W-1:0]       mon_reg, mon_next;
    logic signed [DAYS_W-1:0] days_reg, days_next;
    logic                     leap_reg;
    logic                     ok_reg, ok_next;

    // Stored date.
    logic [YEAR_W-1:0]  cur_year_reg, cur_year_next;
    logic [MONTH_W-1:0] cur_month_reg, cur_month_next;
    logic [DAY_W-1:0]   cur_day_reg, cur_day_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic               m_ok_reg;
    logic [YEAR_W-1:0]  m_year_reg;
    logic [MONTH_W-1:0] m_month_reg;
    logic [DAY_W-1:0]   m_day_reg;

    logic                     out_free;
    logic [DAY_W-1:0]         dim;
    logic signed [DAYS_W-1:0] dim_s;
    logic signed [DAYS_W-1:0] diy_s;
    logic                     set_ok;

    // Month and year lengths for the working year and month.
    assign dim    = month_days(mon_reg, leap_reg);
    assign dim_s  = $signed(DAYS_W'(dim));
    assign diy_s  = leap_reg ? $signed(DAYS_W'(DAYS_LEAP_YEAR)) : $signed(DAYS_W'(DAYS_YEAR));
    assign out_free = !m_valid_reg || out_ready;
    assign set_ok = (yr_reg <= WYEAR_W'(YEAR_LIM)) && (dim != '0) &&
                    (days_reg > 0) && (days_reg <= dim_s);

    // Flags for the sequencer's branch tests.
    assign flags.func        = func_reg;
    assign flags.msum_done   = (mon_reg >= cur_month_reg) || (mon_reg > MONTH_W'(MONTHS));
    assign flags.days_pos    = (days_reg > 0);
    assign flags.yr_zero     = (yr_reg == '0);
    assign flags.yr_over     = (yr_reg > WYEAR_W'(YEAR_LIM));
    assign flags.days_le_diy = (days_reg <= diy_s);
    assign flags.days_le_dim = (days_reg <= dim_s);
    assign flags.out_free    = out_free;

    // Operation decode.
    always_comb begin
        yr_next        = yr_reg;
        mon_next       = mon_reg;
        days_next      = days_reg;
        ok_next        = ok_reg;
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        m_valid_next   = m_valid_reg && !out_ready;
        case (op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                if (func_reg) begin
                    yr_next   = WYEAR_W'(cur_year_reg);
                    mon_next  = MONTH_W'(1);
                    days_next = $signed(DAYS_W'(cur_day_reg));
                end else begin
                    yr_next   = WYEAR_W'(yin_reg);
                    mon_next  = min_reg;
                    days_next = $signed(DAYS_W'(din_reg));
                end
            end
            OP_SET_CHK: begin
                ok_next = set_ok;
                if (set_ok) begin
                    cur_year_next  = yr_reg[YEAR_W-1:0];
                    cur_month_next = mon_reg;
                    cur_day_next   = days_reg[DAY_W-1:0];
                end
            end
            OP_ADD_MON: begin
                days_next = days_reg + dim_s;
                mon_next  = mon_reg + MONTH_W'(1);
            end
            OP_ADD_OFF: begin
                days_next = days_reg + DAYS_W'(off_reg);
            end
            OP_DEC_YR: begin
                yr_next = yr_reg - WYEAR_W'(1);
            end
            OP_ADD_YEAR: begin
                days_next = days_reg + diy_s;
            end
            OP_SUB_YEAR: begin
                days_next = days_reg - diy_s;
                yr_next   = yr_reg + WYEAR_W'(1);
            end
            OP_MON_ONE: begin
                mon_next = MONTH_W'(1);
            end
            OP_SUB_MON: begin
                days_next = days_reg - dim_s;
                mon_next  = mon_reg + MONTH_W'(1);
            end
            OP_COMMIT: begin
                ok_next        = 1'b1;
                cur_year_next  = yr_reg[YEAR_W-1:0];
                cur_month_next = mon_reg;
                cur_day_next   = days_reg[DAY_W-1:0];
            end
            OP_FAIL: begin
                ok_next = 1'b0;
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state and the stored date.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_year_reg  <= '0;
            cur_month_reg <= '0;
            cur_day_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_year_reg  <= cur_year_next;
            cur_month_reg <= cur_month_next;
            cur_day_reg   <= cur_day_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers; the leap flag follows the working year in the next cycle.
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= func_in;
            yin_reg  <= year_in;
            min_reg  <= month_in;
            din_reg  <= day_in;
            off_reg  <= day_offset;
        end
        yr_reg   <= yr_next;
        mon_reg  <= mon_next;
        days_reg <= days_next;
        ok_reg   <= ok_next;
        leap_reg <= is_leap(yr_reg);
        if ((op == OP_EMIT) && out_free) begin
            m_ok_reg    <= ok_reg;
            m_year_reg  <= cur_year_reg;
            m_month_reg <= cur_month_reg;
            m_day_reg   <= cur_day_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign ok_out    = m_ok_reg;
    assign year_out  = m_year_reg;
    assign month_out = m_month_reg;
    assign day_out   = m_day_reg;

    // A committed day lies inside the month that the walk found.
    a_commit_day: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_COMMIT) |-> ((days_reg > 0) && (days_reg <= dim_s)))
        else $error("committed day outside its month");

    // A committed year stays within the year limit.
    a_commit_year: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_COMMIT) |-> (yr_reg <= WYEAR_W'(YEAR_LIM)))
        else $error("committed year above the limit");

    // The stored date is either the reset date or has a real month and day.
    a_stored_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_month_reg == '0) |->
            ((cur_day_reg == '0) && (cur_year_reg == '0)))
        else $error("stored date has no month but a day or year");

endmodule

`default_nettype wire
